### sv/ksm_pkg.sv
// ksm_pkg: shared types and sequencer states for the k-th smallest matrix unit
// no dependencies
package ksm_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] kth_value;
        logic [3:0]         kth_row;
        logic [3:0]         kth_col;
        logic               error;
    } t_out_item;

    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_COL_COUNT   = 2'd1;
    localparam logic [1:0] CFG_RANK_WANTED = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SEED,
        ST_SCAN,
        ST_POP,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_DONE
    } t_state;

endpackage

### sv/kth_smallest_sorted_matrix_unit.sv
// kth_smallest_sorted_matrix_unit: top level, loader, visited map, frontier list
// and the sequencer that drives one shared key compare; uses ksm_pkg, ksm_matrix_ram
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_ready  | ksm_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_ready| ksm_pkg::t_out_item
//  cfg     | input     | i_cfg_valid/o_cfg_ready| index (2b) and data (9b)
//
// loading takes one element a cycle while the unit is in load and no result waits;
// the transaction with last_element set starts selection: a clearing sweep of the
// whole visited map, one cell a cycle, and a push of the seed cell, then per pop a
// linear scan of the frontier through the one compare unit, a pop and up to two
// neighbor pushes (below and right); a final state raises the result.
// not ready while selecting or while the result waits.
// reset is synchronous active low and returns the unit to load.
module kth_smallest_sorted_matrix_unit #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int HEAP_DEPTH = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ksm_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ksm_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [8:0]           i_cfg_data
);
    import ksm_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int HW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int HCW   = $clog2(HEAP_DEPTH + 1);
    localparam int VW    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    // configuration
    logic [4:0] r_rows_cfg, r_cols_cfg;
    logic [8:0] r_rank;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 5'd16;
            r_cols_cfg <= 5'd16;
            r_rank     <= 9'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:   r_rows_cfg <= i_cfg_data[4:0];
                CFG_COL_COUNT:   r_cols_cfg <= i_cfg_data[4:0];
                CFG_RANK_WANTED: r_rank     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [6:0] rows, cols;
    assign rows = (32'(r_rows_cfg) > MAX_ROWS) ? 7'(MAX_ROWS) : 7'(r_rows_cfg);
    assign cols = (32'(r_cols_cfg) > MAX_COLS) ? 7'(MAX_COLS) : 7'(r_cols_cfg);
    logic [13:0] total;
    assign total = 14'(rows) * 14'(cols);

    t_state r_state, n_state;
    logic [CW-1:0]  r_load, n_load;
    logic [AW-1:0]  r_clr, n_clr;
    logic [CELLS-1:0] r_vis;
    logic [HCW-1:0] r_cnt, n_cnt;
    logic [HW-1:0]  r_scan, n_scan, r_best, n_best;
    logic [8:0]     r_pops, n_pops;
    logic [6:0]     r_prow, n_prow, r_pcol, n_pcol;   // cell being pushed
    logic           r_pdown, n_pdown;                 // push of the below neighbor pending
    logic [6:0]     r_drow, n_drow, r_dcol, n_dcol;   // last popped cell
    t_out_item      r_out, n_out;
    logic           r_ovalid, n_ovalid;

    // frontier list: value, row, col per entry
    logic signed [VW-1:0] r_hval [HEAP_DEPTH];
    logic [5:0]           r_hrow [HEAP_DEPTH];
    logic [5:0]           r_hcol [HEAP_DEPTH];

    // matrix store
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;
    ksm_matrix_ram #(.DEPTH(CELLS), .DW(VW), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_load[AW-1:0]),
        .i_wdata(i_in_data.value[VW-1:0]),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic in_fire;
    assign o_in_ready = (r_state == ST_LOAD) && !r_ovalid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign ram_we     = in_fire && (32'(r_load) < CELLS);

    logic [13:0] pidx;
    assign pidx = 14'(r_prow) * 14'(cols) + 14'(r_pcol);
    assign ram_raddr = pidx[AW-1:0];

    // shared key compare: entry at r_scan against entry at r_best
    logic less;
    always_comb begin
        if (r_hval[r_scan] != r_hval[r_best]) less = r_hval[r_scan] < r_hval[r_best];
        else if (r_hrow[r_scan] != r_hrow[r_best]) less = r_hrow[r_scan] < r_hrow[r_best];
        else less = r_hcol[r_scan] < r_hcol[r_best];
    end

    logic vis_set, vis_hit, heap_wr, heap_mv;
    logic r_vhit;                                     // visited bit read in push_rd
    logic [HW-1:0] last_i;
    assign last_i  = HW'(r_cnt - HCW'(1));
    assign vis_hit = (32'(pidx) >= CELLS) || r_vis[pidx[AW-1:0]];

    always_comb begin
        n_state = r_state; n_load = r_load; n_clr = r_clr; n_cnt = r_cnt;
        n_scan = r_scan; n_best = r_best; n_pops = r_pops; n_prow = r_prow;
        n_pcol = r_pcol; n_pdown = r_pdown; n_drow = r_drow; n_dcol = r_dcol;
        n_out = r_out; n_ovalid = r_ovalid;
        vis_set = 1'b0; heap_wr = 1'b0; heap_mv = 1'b0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (32'(r_load) < CELLS) n_load = r_load + CW'(1);
                    if (i_in_data.last_element) begin
                        n_load = '0; n_clr = '0; n_state = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (32'(r_clr) == CELLS - 1) begin
                    n_cnt = '0; n_pops = '0;
                    if (r_rank == 9'd0 || 14'(r_rank) > total) begin
                        n_out = '{kth_value: '0, kth_row: '0, kth_col: '0, error: 1'b1};
                        n_state = ST_DONE;
                    end else begin
                        n_prow = '0; n_pcol = '0; n_pdown = 1'b0;
                        // no right neighbor to push after the seed cell
                        n_drow = '0; n_dcol = cols - 7'd1;
                        n_state = ST_PUSH_RD;
                    end
                end
            end
            ST_SCAN: begin
                if (HCW'(r_scan) >= r_cnt) n_state = ST_POP;
                else begin
                    if (less) n_best = r_scan;
                    if (HCW'(r_scan) + HCW'(1) >= r_cnt) n_state = ST_POP;
                    else n_scan = r_scan + HW'(1);
                end
            end
            ST_POP: begin
                n_drow = 7'(r_hrow[r_best]); n_dcol = 7'(r_hcol[r_best]);
                n_out.kth_value = 32'(r_hval[r_best]);
                n_out.kth_row = r_hrow[r_best][3:0];
                n_out.kth_col = r_hcol[r_best][3:0];
                n_out.error = 1'b0;
                heap_mv = 1'b1;
                n_cnt = r_cnt - HCW'(1);
                n_pops = r_pops + 9'd1;
                if (r_pops + 9'd1 >= r_rank) n_state = ST_DONE;
                else begin
                    n_pdown = 1'b1;
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                // pick next neighbor to push
                if (r_pdown) begin
                    n_pdown = 1'b0;
                    if (r_drow + 7'd1 < rows) begin
                        n_prow = r_drow + 7'd1; n_pcol = r_dcol; n_state = ST_PUSH_RD;
                    end
                end else begin
                    n_state = ST_SCAN; n_scan = HW'(1); n_best = '0;
                    if (r_cnt == '0) begin
                        n_out = '{kth_value: '0, kth_row: '0, kth_col: '0, error: 1'b1};
                        n_state = ST_DONE;
                    end
                    if (r_dcol + 7'd1 < cols && !(r_prow == r_drow && r_pcol == r_dcol + 7'd1)) begin
                        n_prow = r_drow; n_pcol = r_dcol + 7'd1; n_state = ST_PUSH_RD;
                    end
                end
            end
            ST_PUSH_RD: n_state = ST_PUSH_WR;
            ST_PUSH_WR: begin
                n_state = ST_SEED;
                if (!r_vhit) begin
                    if (32'(r_cnt) >= HEAP_DEPTH) begin
                        n_out = '{kth_value: '0, kth_row: '0, kth_col: '0, error: 1'b1};
                        n_state = ST_DONE;
                    end else begin
                        vis_set = 1'b1; heap_wr = 1'b1; n_cnt = r_cnt + HCW'(1);
                    end
                end
            end
            ST_DONE: begin
                n_ovalid = 1'b1; n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ST_SEED after a push of the right neighbor must not re-push it: the guard
    // compares the pushed cell with the right neighbor of the popped cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_load <= '0; r_cnt <= '0; r_pops <= '0;
            r_ovalid <= 1'b0; r_vis <= '0;
        end else begin
            r_state <= n_state; r_load <= n_load; r_cnt <= n_cnt; r_pops <= n_pops;
            r_ovalid <= n_ovalid;
            if (r_state == ST_CLEAR) r_vis[r_clr] <= 1'b0;
            if (vis_set) r_vis[pidx[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr <= n_clr; r_scan <= n_scan; r_best <= n_best; r_prow <= n_prow;
        r_pcol <= n_pcol; r_pdown <= n_pdown; r_drow <= n_drow; r_dcol <= n_dcol;
        r_out <= n_out;
        r_vhit <= vis_hit;
        if (heap_wr) begin
            r_hval[r_cnt[HW-1:0]] <= ram_rdata;
            r_hrow[r_cnt[HW-1:0]] <= r_prow[5:0];
            r_hcol[r_cnt[HW-1:0]] <= r_pcol[5:0];
        end
        if (heap_mv) begin
            r_hval[r_best] <= r_hval[last_i];
            r_hrow[r_best] <= r_hrow[last_i];
            r_hcol[r_best] <= r_hcol[last_i];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

### sv/ksm_matrix_ram.sv
// ksm_matrix_ram: element store, one write and one registered read port
// no dependencies
module ksm_matrix_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 32,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
